@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define PDEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PDEC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pdec_pkg.sv @@
// Package for the percent decoder: widths, character codes, queue record
// and status types, hex digit helpers. No dependencies.
`timescale 1ns / 1ps

package pdec_pkg;

  localparam int COUNT_W = 16;
  localparam int LIM_W   = (COUNT_W > 16) ? COUNT_W : 16;
  localparam logic [LIM_W-1:0] CNT_CAP = LIM_W'({COUNT_W{1'b1}});

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_PCT    = 8'h25;
  localparam logic [7:0] CHR_0      = 8'h30;
  localparam logic [7:0] CHR_9      = 8'h39;
  localparam logic [7:0] CHR_UA     = 8'h41;
  localparam logic [7:0] CHR_UF     = 8'h46;
  localparam logic [7:0] CHR_LA     = 8'h61;
  localparam logic [7:0] CHR_LF     = 8'h66;
  localparam logic [7:0] HEX_UC_OFS = CHR_UA - 8'd10;
  localparam logic [7:0] HEX_LC_OFS = CHR_LA - 8'd10;

  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_PCT   = 2'd1;
  localparam logic [1:0] HELD_DIGIT = 2'd2;

  // One accepted byte's worth of results.
  typedef struct packed {
    logic [2:0][7:0]    bytes;
    logic [1:0]         n;
    logic               eos;
    logic [COUNT_W-1:0] base;
  } pdec_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pdec_q_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CHR_0 && c <= CHR_9) || (c >= CHR_UA && c <= CHR_UF) ||
           (c >= CHR_LA && c <= CHR_LF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHR_0 && c <= CHR_9) begin
      v = c - CHR_0;
    end else if (c >= CHR_UA && c <= CHR_UF) begin
      v = c - HEX_UC_OFS;
    end else begin
      v = c - HEX_LC_OFS;
    end
    return v[3:0];
  endfunction

endpackage

@@ hdl/pdec_front.sv @@
// Front end: accepts raw bytes, runs the escape parser and output limit,
// pushes a result record per byte that yields results or ends a string. Uses pdec_pkg.
`timescale 1ns / 1ps

module pdec_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_is_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_max_output,
  input  pdec_pkg::pdec_q_stat_t q_stat,
  output logic                  push,
  output pdec_pkg::pdec_rec_t   rec
);

  logic [15:0]                  max_r;
  logic [1:0]                   held_r, held_nxt;
  logic [7:0]                   digit_r, digit_nxt;
  logic [pdec_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                         stop_r, stop_nxt;

  logic                         acc;
  logic [pdec_pkg::LIM_W-1:0]   lim, room;
  logic [2:0][7:0]              cb;
  logic [2:0]                   nc, n_ok;
  logic                         eos;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign acc       = in_valid && in_ready;

  always_comb begin
    held_nxt  = held_r;
    digit_nxt = digit_r;
    stop_nxt  = stop_r;
    cb        = '0;
    nc        = 3'd0;
    eos       = 1'b0;
    if (stop_r) begin
      if (in_is_last) begin
        stop_nxt = 1'b0;
      end
    end else begin
      if (in_byte != pdec_pkg::CHR_NUL) begin
        case (held_r)
          pdec_pkg::HELD_PCT: begin
            if (pdec_pkg::is_hex(in_byte)) begin
              digit_nxt = in_byte;
              held_nxt  = pdec_pkg::HELD_DIGIT;
            end else begin
              cb[nc[1:0]] = pdec_pkg::CHR_PCT;
              nc = nc + 3'd1;
              held_nxt = pdec_pkg::HELD_NONE;
              if (in_byte == pdec_pkg::CHR_PCT) begin
                held_nxt = pdec_pkg::HELD_PCT;
              end else begin
                cb[nc[1:0]] = in_byte;
                nc = nc + 3'd1;
              end
            end
          end
          pdec_pkg::HELD_DIGIT: begin
            held_nxt = pdec_pkg::HELD_NONE;
            if (pdec_pkg::is_hex(in_byte)) begin
              cb[nc[1:0]] = {pdec_pkg::hex_val(digit_r), pdec_pkg::hex_val(in_byte)};
              nc = nc + 3'd1;
            end else begin
              cb[nc[1:0]] = pdec_pkg::CHR_PCT;
              nc = nc + 3'd1;
              cb[nc[1:0]] = digit_r;
              nc = nc + 3'd1;
              if (in_byte == pdec_pkg::CHR_PCT) begin
                held_nxt = pdec_pkg::HELD_PCT;
              end else begin
                cb[nc[1:0]] = in_byte;
                nc = nc + 3'd1;
              end
            end
          end
          default: begin
            if (in_byte == pdec_pkg::CHR_PCT) begin
              held_nxt = pdec_pkg::HELD_PCT;
            end else begin
              cb[nc[1:0]] = in_byte;
              nc = nc + 3'd1;
            end
          end
        endcase
      end
      if (in_byte == pdec_pkg::CHR_NUL || in_is_last) begin
        // end of string: flush held bytes as literals
        if (held_nxt != pdec_pkg::HELD_NONE) begin
          cb[nc[1:0]] = pdec_pkg::CHR_PCT;
          nc = nc + 3'd1;
        end
        if (held_nxt == pdec_pkg::HELD_DIGIT) begin
          cb[nc[1:0]] = digit_nxt;
          nc = nc + 3'd1;
        end
        eos       = 1'b1;
        held_nxt  = pdec_pkg::HELD_NONE;
        digit_nxt = 8'h00;
        stop_nxt  = (in_byte == pdec_pkg::CHR_NUL) && !in_is_last;
      end
    end
  end

  always_comb begin
    lim  = (pdec_pkg::LIM_W'(max_r) < pdec_pkg::CNT_CAP) ?
           pdec_pkg::LIM_W'(max_r) : pdec_pkg::CNT_CAP;
    room = (pdec_pkg::LIM_W'(cnt_r) < lim) ? (lim - pdec_pkg::LIM_W'(cnt_r)) : '0;
    n_ok = (room >= pdec_pkg::LIM_W'(nc)) ? nc : room[2:0];
    cnt_nxt = eos ? '0 : (cnt_r + pdec_pkg::COUNT_W'(n_ok));
  end

  assign push      = acc && !stop_r && (n_ok != 3'd0 || eos);
  assign rec.bytes = cb;
  assign rec.n     = n_ok[1:0];
  assign rec.eos   = eos;
  assign rec.base  = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= 16'hFFFF;
      held_r  <= pdec_pkg::HELD_NONE;
      digit_r <= 8'h00;
      cnt_r   <= '0;
      stop_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_max_output;
      end
      if (acc) begin
        held_r  <= held_nxt;
        digit_r <= digit_nxt;
        cnt_r   <= stop_r ? cnt_r : cnt_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

endmodule

@@ hdl/pdec_queue.sv @@
// Short record queue between front and back ends.
// Uses pdec_pkg for depth and record type.
`timescale 1ns / 1ps

module pdec_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pdec_pkg::pdec_rec_t    wr_rec,
  input  logic                   pop,
  output pdec_pkg::pdec_rec_t    rd_rec,
  output pdec_pkg::pdec_q_stat_t stat
);

  pdec_pkg::pdec_rec_t          mem_r [pdec_pkg::Q_DEPTH];
  logic [pdec_pkg::Q_PTR_W-1:0] wp_r, rp_r;
  logic [pdec_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == pdec_pkg::Q_CNT_W'(pdec_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_rec     = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/pdec_back.sv @@
// Back end: walks the head record one result a cycle into the output
// register while out_ready does not stall it. Uses pdec_pkg for record and status types.
`timescale 1ns / 1ps

module pdec_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pdec_pkg::pdec_rec_t    head,
  input  pdec_pkg::pdec_q_stat_t q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_has_byte,
  output logic                   out_end_of_string,
  output logic [15:0]            out_byte_count
);

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r;
  logic [7:0]  byte_r;
  logic        has_r, eos_r;
  logic [15:0] count_r;

  logic        load, last;
  logic [7:0]  byte_c;
  logic        has_c, eos_c;
  logic [15:0] count_c;

  always_comb begin
    if (head.n == 2'd0) begin
      last    = 1'b1;
      byte_c  = 8'h00;
      has_c   = 1'b0;
      eos_c   = 1'b1;
      count_c = 16'(head.base);
    end else begin
      last    = (idx_r == head.n - 2'd1);
      byte_c  = head.bytes[idx_r];
      has_c   = 1'b1;
      eos_c   = head.eos && last;
      count_c = 16'(head.base + pdec_pkg::COUNT_W'(idx_r) + pdec_pkg::COUNT_W'(1));
    end
  end

  assign load    = !q_stat.empty && (!valid_r || out_ready);
  assign pop     = load && last;
  assign idx_nxt = pop ? 2'd0 : (load ? idx_r + 2'd1 : idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_c;
      has_r   <= has_c;
      eos_r   <= eos_c;
      count_r <= count_c;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_has_byte      = has_r;
  assign out_end_of_string = eos_r;
  assign out_byte_count    = count_r;

endmodule

@@ hdl/percent_decoder.sv @@
// Top level of the streaming URI percent decoder.
// Instantiates pdec_front, pdec_queue and pdec_back; uses pdec_pkg.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_byte, in_is_last
// out      output     out_valid / out_ready  out_byte, out_has_byte, out_end_of_string,
//                                            out_byte_count
// cfg      input      cfg_valid / cfg_ready  cfg_max_output (always ready)
//
// One byte is accepted per cycle while the two-entry record queue has room.
// A byte yielding k results (0..3) sends them out one at a time, and the back
// end takes no new record until the last result of the head record is loaded.
// A byte's first result passes through the record queue and then the output register.
// Synchronous active-low reset; max_output resets to 65535.
// Output stalls fill the queue and then drop in_ready.
`timescale 1ns / 1ps

module percent_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_end_of_string,
  output logic [15:0] out_byte_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_output
);

  pdec_pkg::pdec_q_stat_t q_stat;
  pdec_pkg::pdec_rec_t    wr_rec, head;
  logic                   push, pop;

  pdec_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_is_last     (in_is_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_output (cfg_max_output),
    .q_stat         (q_stat),
    .push           (push),
    .rec            (wr_rec)
  );

  pdec_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (head),
    .stat   (q_stat)
  );

  pdec_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_has_byte      (out_has_byte),
    .out_end_of_string (out_end_of_string),
    .out_byte_count    (out_byte_count)
  );

endmodule

@@ hdl/pdec_checker.sv @@
// Port-level checker for percent_decoder, bound to the top level.
// Uses assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_byte,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_has_byte,
  input logic        out_end_of_string,
  input logic [15:0] out_byte_count,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_max_output
);

  `PDEC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "out_valid after reset")
  `PDEC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out_valid dropped on stall")
  `PDEC_ASSERT(a_empty_eos, out_valid && !out_has_byte |-> out_end_of_string && out_byte == 8'h00, "empty result not an end marker")
  `PDEC_ASSERT(a_cnt_nz, out_valid && out_has_byte |-> out_byte_count != 16'h0000, "byte result with zero count")

endmodule

bind percent_decoder pdec_checker u_pdec_checker (.*);
